/* design/pei_pkg.sv */
// ----------------------------------------------------------------------------
// pei_pkg
// constants, codes, table and types shared by the optimal input pipeline
// ----------------------------------------------------------------------------
package pei_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;

  localparam int SHIFT      = 30 - FRAC_BITS;
  localparam int MOD_STEPS  = 29 - FRAC_BITS;
  localparam int ABS_W      = 32 + SHIFT;
  localparam int CS_W       = FRAC_BITS + 4;
  localparam int CORDIC_LAT = MOD_STEPS + CORDIC_STEPS + 4;
  localparam int SQRT_LAT   = 32;
  localparam int DIV_LAT    = 31;
  localparam int NUM_END    = 2 + SQRT_LAT;
  localparam int TOTAL_LAT  = 2 + SQRT_LAT + DIV_LAT;
  localparam int SB_BASE    = CORDIC_LAT + 2;

  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [34:0] Q30_GAIN    = 35'sd652032874;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_MAX     = 2'd1;
  localparam logic [1:0] MODE_MIN     = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT_A  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW_A   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH_A  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT_B  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW_B   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH_B  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_DIST_SUM  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_DIST_SUM = 4'd7;

  typedef struct packed {
    logic signed [31:0] speed_a;
    logic signed [31:0] turn_a;
    logic signed [31:0] turn_b;
    logic signed [31:0] dist_head;
    logic               mx_b;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
    logic [1:0]         err;
  } side_t;

  function automatic logic signed [34:0] atan_q30(input int i);
    logic signed [34:0] v;
    case (i)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048575;
      11: v = 35'sd524287;
      12: v = 35'sd262143;
      13: v = 35'sd131071;
      14: v = 35'sd65535;
      15: v = 35'sd32767;
      16: v = 35'sd16383;
      17: v = 35'sd8191;
      18: v = 35'sd4095;
      19: v = 35'sd2047;
      20: v = 35'sd1023;
      21: v = 35'sd511;
      22: v = 35'sd255;
      23: v = 35'sd127;
      24: v = 35'sd63;
      25: v = 35'sd31;
      26: v = 35'sd15;
      27: v = 35'sd7;
      28: v = 35'sd3;
      29: v = 35'sd1;
      default: v = 35'sd0;
    endcase
    return v;
  endfunction

endpackage

/* design/pei_if.sv */
// ----------------------------------------------------------------------------
// pei_if
// valid/ready channels for grid points, results and register writes
// ----------------------------------------------------------------------------
interface pei_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rel_x;
  logic signed [31:0] rel_y;
  logic signed [31:0] rel_heading;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_heading;
  logic [1:0]         ctrl_mode;
  logic [1:0]         dstb_mode;
  modport source (output valid, rel_x, rel_y, rel_heading, grad_x, grad_y, grad_heading,
                  ctrl_mode, dstb_mode, input ready);
  modport sink (input valid, rel_x, rel_y, rel_heading, grad_x, grad_y, grad_heading,
                ctrl_mode, dstb_mode, output ready);
endinterface

interface pei_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_a;
  logic signed [31:0] turn_a;
  logic signed [31:0] speed_b;
  logic signed [31:0] turn_b;
  logic signed [31:0] dist_px;
  logic signed [31:0] dist_py;
  logic signed [31:0] dist_head;
  logic [1:0]         mode_error;
  modport source (output valid, speed_a, turn_a, speed_b, turn_b, dist_px, dist_py,
                  dist_head, mode_error, input ready);
  modport sink (input valid, speed_a, turn_a, speed_b, turn_b, dist_px, dist_py,
                dist_head, mode_error, output ready);
endinterface

interface pei_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/pei_cordic.sv */
// ----------------------------------------------------------------------------
// pei_cordic
// pipelined heading reduction and rotation cordic giving cos and sin
// ----------------------------------------------------------------------------
module pei_cordic import pei_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [31:0]     heading,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic [31:0]        habs;
  logic [ABS_W-1:0]   ma [MOD_STEPS+1];
  logic               mneg [MOD_STEPS+1];
  logic signed [34:0] zs, zw, z1, z2;
  logic               fneg;
  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [34:0] cz [CORDIC_STEPS+1];
  logic               cn [CORDIC_STEPS+1];
  logic signed [33:0] xf, yf, xs, ys;

  assign habs = heading[31] ? $unsigned(-heading) : $unsigned(heading);

  always_ff @(posedge clk) begin
    if (en) begin
      ma[0]   <= ABS_W'(habs) << SHIFT;
      mneg[0] <= heading[31];
    end
  end

  // restoring remainder by two pi, one quotient bit a stage
  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    localparam int B = MOD_STEPS - 1 - k;
    localparam logic [63:0] M = 64'(Q30_TWO_PI) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (64'(ma[k]) >= M) begin
          ma[k+1] <= ma[k] - ABS_W'(M);
        end else begin
          ma[k+1] <= ma[k];
        end
        mneg[k+1] <= mneg[k];
      end
    end
  end

  always_comb begin
    zs = $signed({2'b00, ma[MOD_STEPS][32:0]});
    if (mneg[MOD_STEPS]) begin
      zs = -zs;
    end
    zw = zs;
    if (zs > Q30_PI) begin
      zw = zs - Q30_TWO_PI;
    end else if (zs < -Q30_PI) begin
      zw = zs + Q30_TWO_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= zw;
    end
  end

  always_comb begin
    z2   = z1;
    fneg = 1'b0;
    if (z1 > Q30_HALF_PI) begin
      z2   = z1 - Q30_PI;
      fneg = 1'b1;
    end else if (z1 < -Q30_HALF_PI) begin
      z2   = z1 + Q30_PI;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= 34'(Q30_GAIN);
      cy[0] <= '0;
      cz[0] <= z2;
      cn[0] <= fneg;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q30(i);
        end
        cn[i+1] <= cn[i];
      end
    end
  end

  always_comb begin
    xf = cn[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    yf = cn[CORDIC_STEPS] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
    xs = xf >>> SHIFT;
    ys = yf >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= xs[CS_W-1:0];
      sin_o <= ys[CS_W-1:0];
    end
  end

endmodule

/* design/pei_sqrt.sv */
// ----------------------------------------------------------------------------
// pei_sqrt
// pipelined integer square root, one root bit a stage
// ----------------------------------------------------------------------------
module pei_sqrt import pei_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] sq,
  output logic [31:0] root
);

  logic [63:0] rem [SQRT_LAT];
  logic [63:0] acc [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] rin, ain, trial;
    if (k == 0) begin : g_first
      assign rin = sq;
      assign ain = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign ain = acc[k-1];
    end
    assign trial = ain + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[k] <= rin - trial;
          acc[k] <= (ain >> 1) + BIT;
        end else begin
          rem[k] <= rin;
          acc[k] <= ain >> 1;
        end
      end
    end
  end

  assign root = acc[SQRT_LAT-1][31:0];

endmodule

/* design/pei_div.sv */
// ----------------------------------------------------------------------------
// pei_div
// pipelined restoring divider of magnitudes, one quotient bit a stage
// ----------------------------------------------------------------------------
module pei_div import pei_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [62:0]  num,
  input  logic [31:0]  den,
  output logic [30:0]  quo
);

  logic [62:0] rem [DIV_LAT];
  logic [31:0] dv  [DIV_LAT];
  logic [30:0] qa  [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_st
    localparam int B = DIV_LAT - 1 - k;
    logic [62:0] rin, sub;
    logic [31:0] din;
    logic [30:0] qin;
    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign din = dv[k-1];
      assign qin = qa[k-1];
    end
    assign sub = 63'(din) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= sub) begin
          rem[k] <= rin - sub;
          qa[k]  <= qin | (31'(1) << B);
        end else begin
          rem[k] <= rin;
          qa[k]  <= qin;
        end
        dv[k] <= din;
      end
    end
  end

  assign quo = qa[DIV_LAT-1];

endmodule

/* design/pursuit_evasion_optimal_inputs.sv */
// ----------------------------------------------------------------------------
// pursuit_evasion_optimal_inputs
// bang-bang optimal control and disturbance for a relative two-vehicle state
// ----------------------------------------------------------------------------
// points takes one grid point word (position, heading, gradient, modes) on
// valid and ready; results gives one word per point in the same order.
// cfg writes one register per handshake and is always ready; write it only
// while no point is in flight.
// the datapath is a pipeline: heading reduction and cordic on one
// branch, and square root of the gradient norm followed by two dividers on
// the other. one point can be taken every cycle while results does not
// stall; the root plus divider chain sets the depth.
// when results stalls the whole pipeline holds and points.ready drops;
// nothing is lost or repeated.
// reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module pursuit_evasion_optimal_inputs import pei_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pei_cfg_if.sink      cfg,
  pei_in_if.sink       points,
  pei_out_if.source    results
);

  logic [30:0]        turn_limit_a, turn_limit_b, pos_dist_sum, head_dist_sum;
  logic signed [31:0] speed_low_a, speed_high_a, speed_low_b, speed_high_b;

  logic en;
  logic v [TOTAL_LAT+1];

  logic signed [31:0] x0, y0, h0, gx0, gy0, gh0;
  logic [1:0]         cm0, dm0;
  logic [31:0]        agx0, agy0;

  logic signed [63:0] p_xy, p_yx, gh_s, sq_x, sq_y;
  logic [62:0]        num_x, num_y;
  logic               gx_le0, gx_neg1, gy_neg1, gh_ge1, zero1;
  logic [1:0]         cm1, dm1;

  logic signed [65:0] dif;
  logic               ge_a, mxa, mxb, err_a, err_b;
  logic signed [31:0] wa;
  side_t              side_next;
  side_t              sd [2:TOTAL_LAT];
  logic [63:0]        sumsq;

  logic [62:0]        nx [2:NUM_END];
  logic [62:0]        ny [2:NUM_END];
  logic [31:0]        root;
  logic [30:0]        qx, qy;

  logic signed [CS_W-1:0] cs_c, cs_s;
  logic signed [31:0]     gxl [1:CORDIC_LAT];
  logic signed [31:0]     gyl [1:CORDIC_LAT];
  logic signed [63:0]     pc, ps;
  logic signed [64:0]     bsum;
  logic                   sb [SB_BASE:TOTAL_LAT];

  side_t sf;

  // register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_limit_a  <= 31'd65536;
      speed_low_a   <= 32'sd0;
      speed_high_a  <= 32'sd65536;
      turn_limit_b  <= 31'd65536;
      speed_low_b   <= 32'sd0;
      speed_high_b  <= 32'sd65536;
      pos_dist_sum  <= 31'd0;
      head_dist_sum <= 31'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TURN_LIMIT_A:  turn_limit_a  <= cfg.data[30:0];
        REG_SPEED_LOW_A:   speed_low_a   <= $signed(cfg.data);
        REG_SPEED_HIGH_A:  speed_high_a  <= $signed(cfg.data);
        REG_TURN_LIMIT_B:  turn_limit_b  <= cfg.data[30:0];
        REG_SPEED_LOW_B:   speed_low_b   <= $signed(cfg.data);
        REG_SPEED_HIGH_B:  speed_high_b  <= $signed(cfg.data);
        REG_POS_DIST_SUM:  pos_dist_sum  <= cfg.data[30:0];
        REG_HEAD_DIST_SUM: head_dist_sum <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  assign en           = !results.valid || results.ready;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= TOTAL_LAT; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= points.valid;
      for (int i = 1; i <= TOTAL_LAT; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // input word
  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= points.rel_x;
      y0  <= points.rel_y;
      h0  <= points.rel_heading;
      gx0 <= points.grad_x;
      gy0 <= points.grad_y;
      gh0 <= points.grad_heading;
      cm0 <= (points.ctrl_mode == MODE_DEFAULT) ? MODE_MAX : points.ctrl_mode;
      dm0 <= (points.dstb_mode == MODE_DEFAULT) ? MODE_MIN : points.dstb_mode;
    end
  end

  assign agx0 = gx0[31] ? $unsigned(-gx0) : $unsigned(gx0);
  assign agy0 = gy0[31] ? $unsigned(-gy0) : $unsigned(gy0);

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      p_xy    <= 64'(gx0) * 64'(y0);
      p_yx    <= 64'(gy0) * 64'(x0);
      gh_s    <= 64'(gh0) <<< FRAC_BITS;
      sq_x    <= 64'(gx0) * 64'(gx0);
      sq_y    <= 64'(gy0) * 64'(gy0);
      num_x   <= 63'(pos_dist_sum) * 63'(agx0);
      num_y   <= 63'(pos_dist_sum) * 63'(agy0);
      gx_le0  <= (gx0 <= 0);
      gx_neg1 <= gx0[31];
      gy_neg1 <= gy0[31];
      gh_ge1  <= !gh0[31];
      zero1   <= (gx0 == 0) && (gy0 == 0);
      cm1     <= cm0;
      dm1     <= dm0;
    end
  end

  // mode decisions
  always_comb begin
    dif   = 66'(p_xy) - 66'(gh_s) - 66'(p_yx);
    ge_a  = !dif[65];
    mxa   = (cm1 == MODE_MAX);
    err_a = (cm1 == MODE_UNKNOWN);
    mxb   = (dm1 == MODE_MAX);
    err_b = (dm1 == MODE_UNKNOWN);
    wa    = mxa ? $signed({1'b0, turn_limit_a}) : -$signed({1'b0, turn_limit_a});

    side_next.speed_a = (gx_le0 == mxa) ? speed_high_a : speed_low_a;
    side_next.turn_a  = ge_a ? wa : -wa;
    side_next.turn_b  = (gh_ge1 == mxb) ? $signed({1'b0, turn_limit_b})
                                        : -$signed({1'b0, turn_limit_b});
    side_next.dist_head = (gh_ge1 == mxb) ? $signed({1'b0, head_dist_sum})
                                          : -$signed({1'b0, head_dist_sum});
    if (err_a) begin
      side_next.speed_a = '0;
      side_next.turn_a  = '0;
    end
    if (err_b) begin
      side_next.turn_b    = '0;
      side_next.dist_head = '0;
    end
    side_next.mx_b  = mxb;
    side_next.neg_x = gx_neg1 ^ !mxb;
    side_next.neg_y = gy_neg1 ^ !mxb;
    side_next.zero  = zero1;
    side_next.err   = {err_b, err_a};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq <= $unsigned(sq_x) + $unsigned(sq_y);
      sd[2] <= side_next;
      for (int i = 3; i <= TOTAL_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
      nx[2] <= num_x;
      ny[2] <= num_y;
      for (int i = 3; i <= NUM_END; i++) begin
        nx[i] <= nx[i-1];
        ny[i] <= ny[i-1];
      end
    end
  end

  pei_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .sq   (sumsq),
    .root (root)
  );

  pei_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx[NUM_END]),
    .den (root),
    .quo (qx)
  );

  pei_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny[NUM_END]),
    .den (root),
    .quo (qy)
  );

  // heading branch
  pei_cordic u_cordic (
    .clk     (clk),
    .en      (en),
    .heading (h0),
    .cos_o   (cs_c),
    .sin_o   (cs_s)
  );

  assign bsum = 65'(pc) + 65'(ps);

  always_ff @(posedge clk) begin
    if (en) begin
      gxl[1] <= gx0;
      gyl[1] <= gy0;
      for (int i = 2; i <= CORDIC_LAT; i++) begin
        gxl[i] <= gxl[i-1];
        gyl[i] <= gyl[i-1];
      end
      pc <= 64'(gxl[CORDIC_LAT]) * 64'(cs_c);
      ps <= 64'(gyl[CORDIC_LAT]) * 64'(cs_s);
      sb[SB_BASE] <= !bsum[64];
      for (int i = SB_BASE + 1; i <= TOTAL_LAT; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // result word
  assign sf = sd[TOTAL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= v[TOTAL_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.speed_a    <= sf.speed_a;
      results.turn_a     <= sf.turn_a;
      results.turn_b     <= sf.turn_b;
      results.dist_head  <= sf.dist_head;
      results.mode_error <= sf.err;
      if (sf.err[1]) begin
        results.speed_b <= '0;
      end else begin
        results.speed_b <= (sb[TOTAL_LAT] == sf.mx_b) ? speed_high_b : speed_low_b;
      end
      if (sf.err[1] || sf.zero) begin
        results.dist_px <= '0;
        results.dist_py <= '0;
      end else begin
        results.dist_px <= sf.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        results.dist_py <= sf.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      end
    end
  end

endmodule

/* bench/tb_pursuit_evasion_optimal_inputs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pursuit_evasion_optimal_inputs
// drives grid point words at random rates across several register settings,
// predicts each result word with a local bang-bang and cordic model and
// compares every field of each result word in order
// ----------------------------------------------------------------------------
module tb_pursuit_evasion_optimal_inputs;
  import pei_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_heading;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_heading;
    logic [1:0]         ctrl_mode;
    logic [1:0]         dstb_mode;
  } point_t;

  typedef struct packed {
    logic signed [31:0] speed_a;
    logic signed [31:0] turn_a;
    logic signed [31:0] speed_b;
    logic signed [31:0] turn_b;
    logic signed [31:0] dist_px;
    logic signed [31:0] dist_py;
    logic signed [31:0] dist_head;
    logic [1:0]         mode_error;
  } inputs_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   src_idle = 0;
  int   snk_idle = 0;
  int   quiet = 0;
  inputs_t optimal_q[$];

  longint lim_turn_a, lo_a, hi_a, lim_turn_b, lo_b, hi_b, pos_sum, head_sum;

  pei_cfg_if cfg ();
  pei_in_if  points ();
  pei_out_if results ();

  pursuit_evasion_optimal_inputs dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .points(points.sink), .results(results.source)
  );

  always #4 clk = ~clk;

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    points.valid = 1'b0;
    {points.rel_x, points.rel_y, points.rel_heading} = '0;
    {points.grad_x, points.grad_y, points.grad_heading} = '0;
    points.ctrl_mode = '0;
    points.dstb_mode = '0;
    results.ready = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[31] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048575, 524287, 262143,
                      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                      127, 63, 31, 15, 7, 3, 1, 0};
    return t[i];
  endfunction

  task automatic heading_sin_cos(longint h, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = (h * (64'sd1 << (30 - FRAC_BITS))) % 64'sd6746518852;
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 31; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = floor_shift(x, 30 - FRAC_BITS);
    s = floor_shift(y, 30 - FRAC_BITS);
  endtask

  task automatic predict_optimal(point_t p, output inputs_t r);
    longint x, y, h, gx, gy, gh, w, hd, pd, c, s, n, lhs;
    logic [1:0] cm, dm;
    bit mx;
    x = p.rel_x; y = p.rel_y; h = p.rel_heading;
    gx = p.grad_x; gy = p.grad_y; gh = p.grad_heading;
    cm = (p.ctrl_mode == MODE_DEFAULT) ? MODE_MAX : p.ctrl_mode;
    dm = (p.dstb_mode == MODE_DEFAULT) ? MODE_MIN : p.dstb_mode;
    r = '0;
    if (cm == MODE_UNKNOWN) begin
      r.mode_error[0] = 1'b1;
    end else begin
      mx = (cm == MODE_MAX);
      w = mx ? lim_turn_a : -lim_turn_a;
      lhs = gx * y - gh * (64'sd1 << FRAC_BITS);
      r.turn_a = 32'((lhs >= gy * x) ? w : -w);
      if (gx <= 0) r.speed_a = 32'(mx ? hi_a : lo_a);
      else r.speed_a = 32'(mx ? lo_a : hi_a);
    end
    if (dm == MODE_UNKNOWN) begin
      r.mode_error[1] = 1'b1;
    end else begin
      mx = (dm == MODE_MAX);
      w = mx ? lim_turn_b : -lim_turn_b;
      hd = mx ? head_sum : -head_sum;
      pd = mx ? pos_sum : -pos_sum;
      heading_sin_cos(h, c, s);
      if (gx * c + gy * s >= 0) r.speed_b = 32'(mx ? hi_b : lo_b);
      else r.speed_b = 32'(mx ? lo_b : hi_b);
      r.turn_b = 32'((gh >= 0) ? w : -w);
      r.dist_head = 32'((gh >= 0) ? hd : -hd);
      n = isqrt(longint'(64'(gx * gx) + 64'(gy * gy)));
      if (n != 0) begin
        r.dist_px = 32'(clamp32((pd * gx) / n));
        r.dist_py = 32'(clamp32((pd * gy) / n));
      end
    end
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_TURN_LIMIT_A:  lim_turn_a = val[30:0];
      REG_SPEED_LOW_A:   lo_a = signed'(val);
      REG_SPEED_HIGH_A:  hi_a = signed'(val);
      REG_TURN_LIMIT_B:  lim_turn_b = val[30:0];
      REG_SPEED_LOW_B:   lo_b = signed'(val);
      REG_SPEED_HIGH_B:  hi_b = signed'(val);
      REG_POS_DIST_SUM:  pos_sum = val[30:0];
      REG_HEAD_DIST_SUM: head_sum = val[30:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    points.valid <= 1'b0;
    while (optimal_q.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    inputs_t e;
    while ($urandom_range(99) < src_idle) begin
      points.valid <= 1'b0;
      @(posedge clk);
    end
    points.valid <= 1'b1;
    {points.rel_x, points.rel_y, points.rel_heading, points.grad_x, points.grad_y,
     points.grad_heading, points.ctrl_mode, points.dstb_mode} <= p;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    predict_optimal(p, e);
    optimal_q.push_back(e);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4: return 32'(signed'($urandom_range(200)) - 100);
      5: return 32'(signed'($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.rel_x = edge_word();
    p.rel_y = edge_word();
    p.rel_heading = edge_word();
    p.grad_x = edge_word();
    p.grad_y = edge_word();
    p.grad_heading = edge_word();
    p.ctrl_mode = 2'($urandom_range(3));
    p.dstb_mode = 2'($urandom_range(3));
    return p;
  endfunction

  task automatic test_directed();
    point_t p;
    logic [31:0] ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int m = 0; m < 16; m++) begin
      p = random_point();
      p.ctrl_mode = m[1:0];
      p.dstb_mode = m[3:2];
      send_point(p);
    end
    for (int k = 0; k < 4; k++) begin
      p = '{ext[k], ext[k], ext[k], ext[k], ext[k], ext[k], MODE_MAX, MODE_MAX};
      send_point(p);
    end
    p = '{32'h10000, 32'h20000, 32'h3243f, 32'h0, 32'h0, 32'h5, MODE_MAX, MODE_MAX};
    send_point(p);
    p = '{32'h10000, 32'h10000, 32'h0, 32'h10000, 32'h10000, 32'h0, MODE_MIN, MODE_MIN};
    send_point(p);
    p = '{32'h0, 32'h0, 32'hfffcdbc1, 32'h7fff_ffff, 32'h1, 32'h0, MODE_MAX, MODE_MAX};
    send_point(p);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_point(random_point());
  endtask

  task automatic test_settings(int phase);
    logic [31:0] v;
    wait_drained();
    for (int r = 0; r < 8; r++) begin
      case (phase)
        0: v = (r == 1 || r == 2 || r == 4 || r == 5) ? 32'h8000_0000 : 32'h7fff_ffff;
        1: v = (r == 1 || r == 2 || r == 4 || r == 5) ? 32'h7fff_ffff : 32'h0;
        default: v = $urandom;
      endcase
      write_reg(r[3:0], v);
    end
    write_reg(4'd9, $urandom);
    cfg.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      results.ready <= ($urandom_range(99) >= snk_idle);
      if (results.valid && results.ready) begin
        if (optimal_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          inputs_t e;
          e = optimal_q.pop_front();
          if (results.speed_a !== e.speed_a) begin
            $error("speed_a exp %0d got %0d", e.speed_a, results.speed_a); errors++;
          end
          if (results.turn_a !== e.turn_a) begin
            $error("turn_a exp %0d got %0d", e.turn_a, results.turn_a); errors++;
          end
          if (results.speed_b !== e.speed_b) begin
            $error("speed_b exp %0d got %0d", e.speed_b, results.speed_b); errors++;
          end
          if (results.turn_b !== e.turn_b) begin
            $error("turn_b exp %0d got %0d", e.turn_b, results.turn_b); errors++;
          end
          if (results.dist_px !== e.dist_px) begin
            $error("dist_px exp %0d got %0d", e.dist_px, results.dist_px); errors++;
          end
          if (results.dist_py !== e.dist_py) begin
            $error("dist_py exp %0d got %0d", e.dist_py, results.dist_py); errors++;
          end
          if (results.dist_head !== e.dist_head) begin
            $error("dist_head exp %0d got %0d", e.dist_head, results.dist_head); errors++;
          end
          if (results.mode_error !== e.mode_error) begin
            $error("mode_error exp %0d got %0d", e.mode_error, results.mode_error); errors++;
          end
        end
      end
      if ((results.valid && results.ready) || (points.valid && points.ready) ||
          (cfg.valid && cfg.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    lim_turn_a = 65536; lo_a = 0; hi_a = 65536;
    lim_turn_b = 65536; lo_b = 0; hi_b = 65536;
    pos_sum = 0; head_sum = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 25; snk_idle = 63;
    test_directed();
    test_random(100);
    test_settings(0);
    test_directed();
    test_random(200);
    src_idle = 63; snk_idle = 25;
    test_settings(1);
    test_directed();
    test_random(200);
    test_settings(2);
    test_random(150);
    src_idle = 0; snk_idle = 0;
    test_settings(2);
    test_random(150);
    wait_drained();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
